/* design/crmt_pkg.sv */
// Shared types, constants and codes for the CIDR range membership table.
package crmt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SCAN_W      = IDX_W + 1;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [LEN_W-1:0]       LEN_FULL  = LEN_W'(ADDR_W);

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAT    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic                matched;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      prefix;
    logic [LEN_W-1:0]       length;
    logic [COUNT_WIDTH-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
    logic             used;
  } wr_req_t;

  typedef struct packed {
    logic key_hit;
    logic range_hit;
  } cmp_res_t;

endpackage

/* design/crmt_store.sv */
// Entry memory with registered read port and per-entry used flags.
module crmt_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [crmt_pkg::IDX_W-1:0]  rd_addr,
  output crmt_pkg::entry_t            rd_data,
  output logic                        rd_used,
  input  crmt_pkg::wr_req_t           wr
);

  crmt_pkg::entry_t                     mem [crmt_pkg::TABLE_DEPTH];
  logic [crmt_pkg::TABLE_DEPTH-1:0]     used_r;
  crmt_pkg::entry_t                     rd_data_r;
  logic                                 rd_used_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (wr.en) begin
        used_r[wr.addr] <= wr.used;
      end
      rd_used_r <= used_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign rd_used = rd_used_r;

endmodule

/* design/crmt_match.sv */
// Shared comparator: exact key compare and masked range compare for one entry.
module crmt_match (
  input  crmt_pkg::in_item_t  key,
  input  crmt_pkg::entry_t    entry,
  input  logic                used,
  output crmt_pkg::cmp_res_t  res
);

  logic [crmt_pkg::LEN_W-1:0]  len_sat;
  logic [crmt_pkg::ADDR_W-1:0] mask;

  always_comb begin
    len_sat = (entry.length > crmt_pkg::LEN_FULL) ? crmt_pkg::LEN_FULL : entry.length;
    mask    = ~({crmt_pkg::ADDR_W{1'b1}} >> len_sat);
    res.key_hit   = used && (entry.prefix == key.address) &&
                    (entry.length == key.prefix_len);
    res.range_hit = used && (entry.count != '0) &&
                    (((entry.prefix ^ key.address) & mask) == '0);
  end

endmodule

/* design/cidr_range_membership_table.sv */
// Top level: sequencer that scans the entry table once per command.
//
// Usage: present a command on in_item with start high while busy is low;
// it is taken at that clock edge and busy is high from the next cycle.
// Modes: add range, remove range, query address (prefix_len ignored).
// Every command, unused mode included, gives exactly one result beat on
// out_item, marked by out_valid for a single cycle; the receiver cannot
// stall it, so it must take the beat when it appears.
// Each command walks all 64 entries through one comparator, one entry a
// cycle from the registered read port of the entry memory; the last
// compare is registered, the update is applied in ST_APPLY and the result
// beat is registered from it. A new command may be accepted at the edge
// that ends the result cycle, so a new command is taken only once the last
// one has been through its scan and update.
// A new key goes into the lowest free entry.
// Reset (synchronous, active low) clears every used flag, so the table
// starts empty; entry contents are not cleared and need no clearing pass.
module cidr_range_membership_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  crmt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output crmt_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  crmt_pkg::in_item_t                  cmd_r;
  logic [crmt_pkg::SCAN_W-1:0]         scan_idx_r;
  logic                                chk_vld_r;
  logic [crmt_pkg::IDX_W-1:0]          chk_idx_r;
  logic                                hit_r;
  logic [crmt_pkg::IDX_W-1:0]          hit_idx_r;
  logic [crmt_pkg::COUNT_WIDTH-1:0]    hit_cnt_r;
  logic                                free_r;
  logic [crmt_pkg::IDX_W-1:0]          free_idx_r;
  logic                                match_r;
  logic                                out_valid_r;
  crmt_pkg::out_item_t                 out_item_r;

  logic                                accept;
  logic                                issue;
  crmt_pkg::entry_t                    rd_data;
  logic                                rd_used;
  crmt_pkg::cmp_res_t                  cmp;
  crmt_pkg::wr_req_t                   wr;
  crmt_pkg::out_item_t                 res;

  assign accept = start && (state_r == ST_IDLE);
  assign issue  = (state_r == ST_SCAN) &&
                  (scan_idx_r != crmt_pkg::SCAN_W'(crmt_pkg::TABLE_DEPTH));

  crmt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (scan_idx_r[crmt_pkg::IDX_W-1:0]),
    .rd_data (rd_data),
    .rd_used (rd_used),
    .wr      (wr)
  );

  crmt_match u_match (
    .key   (cmd_r),
    .entry (rd_data),
    .used  (rd_used),
    .res   (cmp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (chk_vld_r && (chk_idx_r == crmt_pkg::IDX_W'(crmt_pkg::TABLE_DEPTH - 1))) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // update and result, worked out once the scan is complete
  always_comb begin
    wr          = '0;
    wr.data     = '{prefix: cmd_r.address, length: cmd_r.prefix_len,
                    count: hit_cnt_r};
    res         = '{matched: 1'b0, status: crmt_pkg::STATUS_OK};
    case (cmd_r.mode)
      crmt_pkg::MODE_ADD: begin
        if (hit_r) begin
          if (hit_cnt_r == crmt_pkg::COUNT_MAX) begin
            res.status = crmt_pkg::STATUS_SAT;
          end else begin
            wr.en         = 1'b1;
            wr.addr       = hit_idx_r;
            wr.data.count = hit_cnt_r + crmt_pkg::COUNT_WIDTH'(1);
            wr.used       = 1'b1;
          end
        end else if (free_r) begin
          wr.en         = 1'b1;
          wr.addr       = free_idx_r;
          wr.data.count = crmt_pkg::COUNT_WIDTH'(1);
          wr.used       = 1'b1;
        end else begin
          res.status = crmt_pkg::STATUS_FULL;
        end
      end
      crmt_pkg::MODE_REMOVE: begin
        if (!hit_r || (hit_cnt_r == '0)) begin
          res.status = crmt_pkg::STATUS_ABSENT;
        end else begin
          wr.en         = 1'b1;
          wr.addr       = hit_idx_r;
          wr.data.count = hit_cnt_r - crmt_pkg::COUNT_WIDTH'(1);
          wr.used       = (hit_cnt_r != crmt_pkg::COUNT_WIDTH'(1));
        end
      end
      crmt_pkg::MODE_QUERY: res.matched = match_r;
      default: ;
    endcase
    wr.en = wr.en && (state_r == ST_APPLY);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_vld_r   <= issue;
      out_valid_r <= (state_r == ST_APPLY);
      if (accept) begin
        scan_idx_r <= '0;
      end else if (issue) begin
        scan_idx_r <= scan_idx_r + crmt_pkg::SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= scan_idx_r[crmt_pkg::IDX_W-1:0];
    if (accept) begin
      cmd_r   <= in_item;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      match_r <= 1'b0;
    end else if (chk_vld_r) begin
      if (cmp.key_hit) begin
        hit_r     <= 1'b1;
        hit_idx_r <= chk_idx_r;
        hit_cnt_r <= rd_data.count;
      end
      if (!rd_used && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
      if (cmp.range_hit) begin
        match_r <= 1'b1;
      end
    end
    if (state_r == ST_APPLY) begin
      out_item_r <= res;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
